// ----- hw/rtl/hcc_pkg.sv -----
// shared types, register indexes and the mod 256 inverse table for the hill cbc block
package hcc_pkg;

    typedef logic [7:0] t_byte;
    typedef logic [2:0][7:0] t_vec;
    typedef logic [2:0][2:0][7:0] t_mat;
    typedef logic [7:0] t_inv_tab [256];

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned WORD_W    = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_ROW0     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_ROW1     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_ROW2     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_VECTOR  = 3'd4;

    localparam logic [WORD_W-1:0] KEY_ROW0_RST = 24'h030201;
    localparam logic [WORD_W-1:0] KEY_ROW1_RST = 24'h060504;
    localparam logic [WORD_W-1:0] KEY_ROW2_RST = 24'h08090B;

    // inverse mod 256 of (i | 1), three newton steps, built at elaboration
    function automatic t_inv_tab f_inv_tab();
        t_inv_tab tab;
        t_byte    d;
        t_byte    x;
        t_byte    dx;
        t_byte    corr;
        for (int i = 0; i < 256; i++) begin
            d = t_byte'(i) | 8'd1;
            x = d;
            for (int n = 0; n < 3; n++) begin
                dx   = t_byte'(d * x);
                corr = 8'd2 - dx;
                x    = t_byte'(x * corr);
            end
            tab[i] = x;
        end
        return tab;
    endfunction

    localparam t_inv_tab INV_TAB = f_inv_tab();

    // row vector times matrix, element j = sum_i v[i] * m[i][j] mod 256
    function automatic t_vec f_vec_mat(t_vec v, t_mat m);
        t_vec  res;
        t_byte s;
        for (int j = 0; j < 3; j++) begin
            s = 8'd0;
            for (int i = 0; i < 3; i++) begin
                s = s + t_byte'(v[i] * m[i][j]);
            end
            res[j] = s;
        end
        return res;
    endfunction

endpackage

// ----- hw/rtl/hill_cipher_cbc_3x3.sv -----
// 3x3 hill cipher mod 256 in cbc mode, one three-byte block per beat
//
// input channel: i_valid / o_ready with i_first_block and i_in_byte0..2.
// output channel: o_valid / i_ready with o_out_byte0..2, one result per input beat.
// config channel: i_cfg_valid / o_cfg_ready, i_cfg_index selects decrypt_mode,
// key_row0..2 or init_vector, i_cfg_data carries the value; o_cfg_ready is always high
// and writes to unknown indexes are dropped.
// an accepted input beat passes the input register, then the matrix multiply and xor
// into the output register. throughput: one block per cycle while i_ready is high and
// no key refill holds o_ready low; the chain register loop stays in the multiply stage.
// decrypt uses an inverse key kept in a four-stage pipeline fed from the key
// registers; after reset and after any key row write o_ready stays low while that
// pipeline refills.
// reset loads the default key, encrypt mode, zero init vector and zero chaining value,
// and empties both stages. when the receiver stalls the output register holds its beat
// and one more input beat can still be taken into the input register.
module hill_cipher_cbc_3x3 (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_first_block,
    input  logic [7:0]                          i_in_byte0,
    input  logic [7:0]                          i_in_byte1,
    input  logic [7:0]                          i_in_byte2,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [7:0]                          o_out_byte0,
    output logic [7:0]                          o_out_byte1,
    output logic [7:0]                          o_out_byte2,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [hcc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [hcc_pkg::WORD_W-1:0]          i_cfg_data
);
    import hcc_pkg::*;

    localparam logic [1:0] KINV_WAIT = 2'd3;

    logic              r_decrypt;
    logic [WORD_W-1:0] r_key_row0;
    logic [WORD_W-1:0] r_key_row1;
    logic [WORD_W-1:0] r_key_row2;
    logic [WORD_W-1:0] r_init_vector;
    logic [1:0]        r_kinv_wait;

    logic              r_s1_vld;
    logic              r_s1_first;
    t_vec              r_s1_blk;
    logic              r_out_vld;
    t_vec              r_out;
    t_vec              r_chain;

    logic              cfg_wr;
    logic              key_wr;
    logic              in_acc;
    logic              out_adv;
    logic              s1_move;
    t_mat              key;
    t_mat              kinv;
    t_vec              chain_cur;
    t_vec              res;
    t_vec              n_chain;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid & o_cfg_ready;
    assign key_wr      = cfg_wr & ((i_cfg_index == CFG_KEY_ROW0) ||
                                   (i_cfg_index == CFG_KEY_ROW1) ||
                                   (i_cfg_index == CFG_KEY_ROW2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decrypt     <= 1'b0;
            r_key_row0    <= KEY_ROW0_RST;
            r_key_row1    <= KEY_ROW1_RST;
            r_key_row2    <= KEY_ROW2_RST;
            r_init_vector <= '0;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                CFG_DECRYPT_MODE: r_decrypt     <= i_cfg_data[0];
                CFG_KEY_ROW0:     r_key_row0    <= i_cfg_data;
                CFG_KEY_ROW1:     r_key_row1    <= i_cfg_data;
                CFG_KEY_ROW2:     r_key_row2    <= i_cfg_data;
                CFG_INIT_VECTOR:  r_init_vector <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // hold off input until the inverse key pipeline reflects the current key
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kinv_wait <= KINV_WAIT;
        end else if (key_wr) begin
            r_kinv_wait <= KINV_WAIT;
        end else if (r_kinv_wait != 2'd0) begin
            r_kinv_wait <= r_kinv_wait - 2'd1;
        end
    end

    assign key[0] = r_key_row0;
    assign key[1] = r_key_row1;
    assign key[2] = r_key_row2;

    hcc_kinv u_kinv (
        .i_clk  (i_clk),
        .i_key  (key),
        .o_kinv (kinv)
    );

    assign out_adv = ~r_out_vld | i_ready;
    assign s1_move = r_s1_vld & out_adv;
    assign o_ready = (~r_s1_vld | out_adv) & (r_kinv_wait == 2'd0);
    assign in_acc  = i_valid & o_ready;

    always_comb begin
        chain_cur = r_s1_first ? t_vec'(r_init_vector) : r_chain;
        if (r_decrypt) begin
            res     = f_vec_mat(r_s1_blk, kinv) ^ chain_cur;
            n_chain = r_s1_blk;
        end else begin
            res     = f_vec_mat(r_s1_blk ^ chain_cur, key);
            n_chain = res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_chain   <= '0;
        end else begin
            if (in_acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_move) begin
                r_s1_vld <= 1'b0;
            end
            if (out_adv) begin
                r_out_vld <= r_s1_vld;
            end
            if (s1_move) begin
                r_chain <= n_chain;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_first <= i_first_block;
            r_s1_blk   <= {i_in_byte2, i_in_byte1, i_in_byte0};
        end
        if (s1_move) begin
            r_out <= res;
        end
    end

    assign o_valid     = r_out_vld;
    assign o_out_byte0 = r_out[0];
    assign o_out_byte1 = r_out[1];
    assign o_out_byte2 = r_out[2];

endmodule

// ----- hw/rtl/hcc_kinv.sv -----
// inverse key pipeline: cofactors, determinant, determinant inverse, adjugate scaling
module hcc_kinv (
    input  logic          i_clk,
    input  hcc_pkg::t_mat i_key,
    output hcc_pkg::t_mat o_kinv
);
    import hcc_pkg::*;

    t_mat  r_cof;
    t_mat  n_cof;
    t_byte r_det;
    t_byte n_det;
    t_byte r_dinv;
    t_mat  r_kinv;
    t_mat  n_kinv;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                n_cof[r][c] = t_byte'(i_key[(r+1)%3][(c+1)%3] * i_key[(r+2)%3][(c+2)%3])
                            - t_byte'(i_key[(r+1)%3][(c+2)%3] * i_key[(r+2)%3][(c+1)%3]);
            end
        end
    end

    // determinant along row 0 of the key
    always_comb begin
        n_det = 8'd0;
        for (int c = 0; c < 3; c++) begin
            n_det = n_det + t_byte'(i_key[0][c] * r_cof[0][c]);
        end
    end

    // even determinant has no inverse: the table inverts the index with its low bit set
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                n_kinv[r][c] = t_byte'(r_cof[c][r] * r_dinv);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cof  <= n_cof;
        r_det  <= n_det;
        r_dinv <= INV_TAB[r_det];
        r_kinv <= n_kinv;
    end

    assign o_kinv = r_kinv;

endmodule

// ----- hw/rtl/hcc_chk.sv -----
// port-level checker for the hill cbc block, bound to the top level
module hcc_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_ready,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [7:0]                    o_out_byte0,
    input logic [7:0]                    o_out_byte1,
    input logic [7:0]                    o_out_byte2,
    input logic                          i_cfg_valid,
    input logic                          o_cfg_ready,
    input logic [hcc_pkg::CFG_IDX_W-1:0] i_cfg_index
);
    import hcc_pkg::*;

    // a stalled output beat stays valid and unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_byte0) &&
                                $stable(o_out_byte1) && $stable(o_out_byte2))
        else $error("output beat dropped or changed while stalled");

    // a new result follows its input beat through the input and output registers
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && o_ready, 2))
        else $error("output beat without a matching input beat");

    // reset empties the block and holds off input while the inverse key refills
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_ready)
        else $error("block not empty or ready right after reset");

    // a key write blocks input while the inverse key is recomputed
    a_key_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready &&
        (i_cfg_index == CFG_KEY_ROW0 || i_cfg_index == CFG_KEY_ROW1 ||
         i_cfg_index == CFG_KEY_ROW2) |=> !o_ready ##1 !o_ready)
        else $error("input accepted before inverse key settled");

endmodule

bind hill_cipher_cbc_3x3 hcc_chk u_hcc_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_out_byte0 (o_out_byte0),
    .o_out_byte1 (o_out_byte1),
    .o_out_byte2 (o_out_byte2),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready),
    .i_cfg_index (i_cfg_index)
);
